>>> rtl/sha512_pkg.sv
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types and constants for the SHA-512 compression block.
// ----------------------------------------------------------------------------
`default_nettype none
package sha512_pkg;

  typedef logic [63:0] word_t;

  // One message word as it leaves the front queue
  typedef struct packed {
    word_t msg_word;
    logic  first_of_message;
    logic  final_block;
  } qent_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  localparam int QDEPTH = 2;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [6:0] i);
    word_t r;
    case (i)
      7'd0: r = 64'h428a2f98d728ae22; 7'd1: r = 64'h7137449123ef65cd;
      7'd2: r = 64'hb5c0fbcfec4d3b2f; 7'd3: r = 64'he9b5dba58189dbbc;
      7'd4: r = 64'h3956c25bf348b538; 7'd5: r = 64'h59f111f1b605d019;
      7'd6: r = 64'h923f82a4af194f9b; 7'd7: r = 64'hab1c5ed5da6d8118;
      7'd8: r = 64'hd807aa98a3030242; 7'd9: r = 64'h12835b0145706fbe;
      7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
      7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
      7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
      7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
      7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
      7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
      7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
      7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
      7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
      7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
      7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
      7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
      7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
      7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
      7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
      7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
      7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
      7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
      7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
      7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
      7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
      7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
      7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
      7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
      7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
      7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
      7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
      7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
      7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
      7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
      7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
      7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
      7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
      7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
      7'd78: r = 64'h5fcb6fab3ad6faec; default: r = 64'h6c44198c4a475817;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction
  function automatic word_t bsig1(input word_t x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction
  function automatic word_t ssig0(input word_t x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction
  function automatic word_t ssig1(input word_t x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage
`default_nettype wire

>>> rtl/sha512_queue.sv
// ----------------------------------------------------------------------------
// sha512_queue
// Front part: a small queue that takes message words from the input channel.
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_queue (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  sha512_pkg::qent_t   in_ent,
  output logic                out_valid,
  input  wire                 out_ready,
  output sha512_pkg::qent_t   out_ent
);

  sha512_pkg::qent_t mem [sha512_pkg::QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'(sha512_pkg::QDEPTH));
  assign out_valid = (count != 2'd0);
  assign out_ent   = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Store the word
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_ent;
  end

endmodule
`default_nettype wire

>>> rtl/sha512_core.sv
// ----------------------------------------------------------------------------
// sha512_core
// Back part: collects 16 words, runs 80 rounds, adds into hash, emits digest after a final block.
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_core (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  sha512_pkg::qent_t   in_ent,
  output logic                digest_valid,
  input  wire                 digest_ready,
  output logic [63:0]         digest_word,
  output logic [2:0]          word_index,
  output logic                last
);

  sha512_pkg::state_t state, state_next;
  sha512_pkg::word_t  hash [8];
  sha512_pkg::word_t  v [8];
  sha512_pkg::word_t  w [16];
  logic [3:0] word_count;
  logic [6:0] round_count;
  logic [2:0] emit_idx;
  logic       is_final;
  logic       take;
  logic       round_last;

  sha512_pkg::word_t w_new, w_cur, t1, t2;

  assign take       = (state == sha512_pkg::ST_LOAD) && in_valid;
  assign round_last = (round_count == 7'd79);
  assign in_ready   = (state == sha512_pkg::ST_LOAD);

  assign digest_valid = (state == sha512_pkg::ST_EMIT);
  assign digest_word  = hash[emit_idx];
  assign word_index   = emit_idx;
  assign last         = (emit_idx == 3'd7);

  // Round datapath: w[0] is the current schedule word, window shifts each round
  always_comb begin
    w_new = w[0] + sha512_pkg::ssig0(w[1]) + w[9] + sha512_pkg::ssig1(w[14]);
    w_cur = w[0];
    t1 = v[7] + sha512_pkg::bsig1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
         + sha512_pkg::round_k(round_count) + w_cur;
    t2 = sha512_pkg::bsig0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sha512_pkg::ST_LOAD:  if (take && word_count == 4'd15) state_next = sha512_pkg::ST_ROUND;
      sha512_pkg::ST_ROUND: if (round_last) state_next = sha512_pkg::ST_ADD;
      sha512_pkg::ST_ADD:   state_next = is_final ? sha512_pkg::ST_EMIT : sha512_pkg::ST_LOAD;
      sha512_pkg::ST_EMIT:  if (digest_ready && emit_idx == 3'd7) state_next = sha512_pkg::ST_LOAD;
      default:              state_next = sha512_pkg::ST_LOAD;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sha512_pkg::ST_LOAD;
      word_count  <= 4'd0;
      round_count <= 7'd0;
      emit_idx    <= 3'd0;
      is_final    <= 1'b0;
    end else begin
      state <= state_next;
      if (take) begin
        word_count <= word_count + 4'd1;
        is_final   <= in_ent.final_block;
      end
      if (state == sha512_pkg::ST_ROUND)
        round_count <= round_last ? 7'd0 : round_count + 7'd1;
      if (digest_valid && digest_ready) emit_idx <= emit_idx + 3'd1;
    end
  end

  // Hash words
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha512_pkg::init_hash(3'(i));
    end else if (take && in_ent.first_of_message) begin
      for (int i = 0; i < 8; i++) hash[i] <= sha512_pkg::init_hash(3'(i));
    end else if (state == sha512_pkg::ST_ADD) begin
      for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
    end
  end

  // Schedule window and working variables
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= in_ent.msg_word;
      if (word_count == 4'd15) begin
        for (int i = 0; i < 8; i++) v[i] <= hash[i];
        if (in_ent.first_of_message)
          for (int i = 0; i < 8; i++) v[i] <= sha512_pkg::init_hash(3'(i));
      end
    end else if (state == sha512_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule
`default_nettype wire

>>> rtl/sha512_compression.sv
// ----------------------------------------------------------------------------
// sha512_compression
// SHA-512 compression over padded 64-bit message words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (valid/ready) carries msg_word with first_of_message and
//   final_block flags; 16 words form one 1024-bit block. first_of_message
//   reloads the initial hash. A front queue of two words takes words while
//   the back part is busy.
//   The back part takes one word a cycle while loading and a word is
//   offered, then runs 80 rounds at one round per cycle (the round
//   datapath is the limit) and then adds the result into the hash.
//   The final_block flag on the sixteenth word decides whether the
//   eight digest words go out, most significant first, word_index 0..7,
//   last on the eighth; one per cycle while ready is high.
//   If the receiver stalls, the digest word holds and the block waits.
//   Reset loads the initial hash and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_compression (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [63:0] msg_word,
  input  wire         first_of_message,
  input  wire         final_block,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [63:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last
);

  sha512_pkg::qent_t in_ent, q_ent;
  logic q_valid, q_ready;

  assign in_ent.msg_word         = msg_word;
  assign in_ent.first_of_message = first_of_message;
  assign in_ent.final_block      = final_block;

  sha512_queue u_queue (
    .clk, .rst, .in_valid, .in_ready, .in_ent,
    .out_valid(q_valid), .out_ready(q_ready), .out_ent(q_ent)
  );

  sha512_core u_core (
    .clk, .rst,
    .in_valid(q_valid), .in_ready(q_ready), .in_ent(q_ent),
    .digest_valid(out_valid), .digest_ready(out_ready),
    .digest_word, .word_index, .last
  );

endmodule
`default_nettype wire

>>> rtl/sha512_checker.sv
// ----------------------------------------------------------------------------
// sha512_port_checks
// Port-level checks for the SHA-512 compression block.
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_port_checks (
  input wire        clk,
  input wire        rst,
  input wire        out_valid,
  input wire        out_ready,
  input wire [63:0] digest_word,
  input wire [2:0]  word_index,
  input wire        last
);

  // Last marks exactly the eighth word
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (word_index == 3'd7)))
    else $error("last flag mismatch");

  // Index steps by one within a digest
  a_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest index did not advance");

  // Stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(digest_word))
    else $error("stalled digest word changed");

  // A digest starts at index zero
  a_start: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> word_index == 3'd0)
    else $error("digest did not start at word zero");

endmodule

bind sha512_compression sha512_port_checks u_checker (
  .clk, .rst, .out_valid, .out_ready, .digest_word, .word_index, .last
);
`default_nettype wire

>>> tb/sv/sha512_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512_checker
// Watches both channels of the SHA-512 compression block. Every accepted
// message word goes into a local SHA-512 predictor. When a final block
// completes, its eight digest words are queued and compared, field by field
// and in order, with the words the block sends out.
// ----------------------------------------------------------------------------
module sha512_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_ready,
  input  wire  [63:0] msg_word,
  input  wire         first_of_message,
  input  wire         final_block,
  input  wire         out_valid,
  input  wire         out_ready,
  input  wire  [63:0] digest_word,
  input  wire  [2:0]  word_index,
  input  wire         last,
  output int          fail_count,
  output int          pending_count
);

  typedef struct {
    sha512_pkg::word_t dword;
    logic [2:0]        idx;
    logic              lst;
  } digest_t;

  sha512_pkg::word_t hash_st [8];
  sha512_pkg::word_t sched [16];
  logic [3:0]        wcount;
  digest_t           digest_q [$];

  assign pending_count = digest_q.size();

  function automatic sha512_pkg::word_t iv_word(input int i);
    sha512_pkg::word_t iv [8];
    iv = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
           64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
           64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    return iv[i];
  endfunction

  function automatic sha512_pkg::word_t ror64(input sha512_pkg::word_t x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // Run the 80 rounds over the loaded block and fold into the hash
  task automatic compress_block();
    sha512_pkg::word_t v [8];
    sha512_pkg::word_t w, t1, t2, s0, s1;
    int s;
    for (int i = 0; i < 8; i++) v[i] = hash_st[i];
    for (int r = 0; r < 80; r++) begin
      s = r & 15;
      if (r >= 16) begin
        s0 = ror64(sched[(s + 1) & 15], 1) ^ ror64(sched[(s + 1) & 15], 8) ^
             (sched[(s + 1) & 15] >> 7);
        s1 = ror64(sched[(s + 14) & 15], 19) ^ ror64(sched[(s + 14) & 15], 61) ^
             (sched[(s + 14) & 15] >> 6);
        sched[s] = sched[s] + s0 + sched[(s + 9) & 15] + s1;
      end
      w  = sched[s];
      t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha512_pkg::round_k(r[6:0]) + w;
      t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] = hash_st[i] + v[i];
  endtask

  // Predict on accepted input words, compare on accepted digest words
  always @(posedge clk) begin
    digest_t d;
    if (rst) begin
      for (int i = 0; i < 8; i++) hash_st[i] = iv_word(i);
      wcount = '0;
      fail_count = 0;
      digest_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h index %0d", digest_word, word_index);
          fail_count++;
        end else begin
          d = digest_q.pop_front();
          if (digest_word !== d.dword) begin
            $error("digest_word: expected %h, got %h", d.dword, digest_word);
            fail_count++;
          end
          if (word_index !== d.idx) begin
            $error("word_index: expected %0d, got %0d", d.idx, word_index);
            fail_count++;
          end
          if (last !== d.lst) begin
            $error("last: expected %0b, got %0b", d.lst, last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (first_of_message)
          for (int i = 0; i < 8; i++) hash_st[i] = iv_word(i);
        sched[wcount] = msg_word;
        if (wcount != 4'd15) begin
          wcount++;
        end else begin
          wcount = '0;
          compress_block();
          if (final_block)
            for (int i = 0; i < 8; i++) begin
              d.dword = hash_st[i];
              d.idx = i[2:0];
              d.lst = (i == 7);
              digest_q.push_back(d);
            end
        end
      end
    end
  end

endmodule

>>> tb/sv/sha512_compression_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha512_compression_tb
// Feeds the SHA-512 compression block with directed and random messages
// in bursts, stalls the digest side, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module sha512_compression_tb;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] msg_word;
  logic        first_of_message;
  logic        final_block;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        last;
  int          fail_count;
  int          pending_count;
  int          burst_left;

  sha512_compression dut (.*);
  sha512_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the digest side: ready is drawn at random, mostly high, with random stalls
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < 30) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // Offer one word, hold it until accepted, then gap per burst pattern
  task automatic send_word(input logic [63:0] w, input logic fst, input logic fin);
    int gap;
    in_valid <= 1'b1;
    msg_word <= w;
    first_of_message <= fst;
    final_block <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = $urandom_range(1, 20);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Send one block; when noisy, first_of_message after the first word and final_block before the sixteenth are random
  task automatic send_block(input int kind, input logic fst, input logic fin,
                            input bit noisy);
    logic [63:0] w;
    for (int i = 0; i < 16; i++) begin
      case (kind)
        0: w = '0;
        1: w = '1;
        2: w = (i == 0) ? 64'h6162638000000000 : (i == 15) ? 64'd24 : 64'd0;
        default: w = {$urandom, $urandom};
      endcase
      send_word(w, (i == 0) ? fst : (noisy && $urandom_range(0, 15) == 0),
                (i == 15) ? fin : (noisy && $urandom_range(0, 1)));
    end
  endtask

  initial begin
    int wait_cycles;
    rst = 1'b1;
    in_valid = 1'b0;
    msg_word = '0;
    first_of_message = 1'b0;
    final_block = 1'b0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: the standard short message, an all-ones block, then an all-zeros block chained onto it
    send_block(2, 1'b1, 1'b1, 1'b0);
    send_block(1, 1'b1, 1'b1, 1'b1);
    send_block(0, 1'b0, 1'b1, 1'b0);
    // random messages of one to three blocks, some with a mid-block reload
    for (int m = 0; m < 7; m++) begin
      int nb;
      nb = $urandom_range(1, 3);
      for (int b = 0; b < nb; b++)
        send_block(3, (b == 0) && ($urandom_range(0, 5) != 0), b == nb - 1, 1'b1);
    end
    // one last block in two runs: five words with final_block set early, then eleven that finish it
    for (int i = 0; i < 5; i++) send_word({$urandom, $urandom}, 1'b0, 1'b1);
    for (int i = 0; i < 11; i++) send_word({$urandom, $urandom}, i == 4, i == 10);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (pending_count != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> sha512_compression.f
rtl/sha512_pkg.sv
rtl/sha512_queue.sv
rtl/sha512_core.sv
rtl/sha512_compression.sv
rtl/sha512_checker.sv
tb/sv/sha512_checker.sv
tb/sv/sha512_compression_tb.sv
